// ===== hdl/bfsvo_pkg.sv =====
// Shared types and constants for the breadth-first visit order block.
package bfsvo_pkg;

  localparam int VTX_W = 6;

  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_TRAVERSE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the input item
    logic start;     // clear marks, queue the start vertex
    logic add_rd_a;  // read row of first endpoint
    logic add_wr_a;  // write row of first endpoint, read row of second
    logic add_wr_b;  // write row of second endpoint
    logic ack;       // load the single result of an add or a rejected item
    logic deq;       // read the queue head
    logic emit;      // load a visit result, read its adjacency row
    logic scan;      // queue the lowest unvisited neighbour, if any
    logic root;      // queue the lowest unvisited vertex as a new root
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_trav;
    logic item_bad;
    logic out_free;
    logic cand_found;
    logic last_emit;
    logic queue_empty;
  } sts_t;

endpackage

// ===== hdl/bfsvo_dp.sv =====
// Datapath: adjacency row store, pending queue, visited marks and result register.
module bfsvo_dp #(
  parameter int VERTICES = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bfsvo_pkg::cmd_t           cmd,
  output bfsvo_pkg::sts_t           sts,
  input  logic                      action,
  input  logic [bfsvo_pkg::VTX_W-1:0] first_vertex,
  input  logic [bfsvo_pkg::VTX_W-1:0] second_vertex,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bfsvo_pkg::VTX_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bfsvo_pkg::VTX_W-1:0] visited_vertex,
  output logic                      last,
  output logic                      invalid
);

  localparam int VW = $clog2(VERTICES);
  localparam logic [bfsvo_pkg::VTX_W:0] VMAX = (bfsvo_pkg::VTX_W+1)'(VERTICES);

  typedef logic [bfsvo_pkg::VTX_W-1:0] vtx_t;
  typedef logic [VERTICES-1:0]         row_t;

  function automatic logic [VW-1:0] vidx(input vtx_t v);
    logic [bfsvo_pkg::VTX_W-1:0] d;
    d = v - 1'b1;
    return VW'(d);
  endfunction

  function automatic row_t onehot(input logic [VW-1:0] i);
    return {{(VERTICES-1){1'b0}}, 1'b1} << i;
  endfunction

  // Lowest set bit: {found, index}.
  function automatic logic [VW:0] lowest(input row_t v);
    logic [VW:0] r;
    r = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, VW'(i)};
    end
    return r;
  endfunction

  // Configuration and latched item
  vtx_t vertex_count;
  logic act;
  vtx_t va, vb;
  vtx_t n;
  logic a_ok, b_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= vtx_t'(32);
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act <= action;
      va  <= first_vertex;
      vb  <= second_vertex;
    end
  end

  assign n    = ({1'b0, vertex_count} > VMAX) ? vtx_t'(VMAX) : vertex_count;
  assign a_ok = (va != '0) && (va <= n);
  assign b_ok = (vb != '0) && (vb <= n);

  // Adjacency row store with per-row valid bits
  row_t             row_mem [VERTICES];
  logic [VERTICES-1:0] row_vld;
  row_t             rd_data;
  logic             rd_vld;
  row_t             row_q;
  logic             row_we, row_re;
  logic [VW-1:0]    row_waddr, row_raddr;
  row_t             row_wdata;

  // Pending queue
  vtx_t             q_mem [VERTICES];
  vtx_t             q_rdata;
  logic [VW:0]      head, tail;
  logic             q_we;
  logic [VW-1:0]    q_waddr;
  vtx_t             q_wdata;

  row_t             visited;
  row_t             mask;
  row_t             cand_vec;
  logic [VW:0]      cand, unv;
  vtx_t             emit_cnt;

  always_comb begin
    for (int i = 0; i < VERTICES; i++) begin
      mask[i] = (i < int'(n));
    end
  end

  assign row_q    = rd_vld ? rd_data : '0;
  assign cand_vec = row_q & ~visited & mask;
  assign cand     = lowest(cand_vec);
  assign unv      = lowest(~visited & mask);

  always_comb begin
    row_we    = cmd.add_wr_a | cmd.add_wr_b;
    row_waddr = cmd.add_wr_a ? vidx(va) : vidx(vb);
    row_wdata = cmd.add_wr_a ? (row_q | onehot(vidx(vb))) : (row_q | onehot(vidx(va)));
    row_re    = cmd.add_rd_a | cmd.add_wr_a | cmd.emit;
    priority if (cmd.add_rd_a) row_raddr = vidx(va);
    else if (cmd.add_wr_a)     row_raddr = vidx(vb);
    else                       row_raddr = vidx(q_rdata);
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) rd_data <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (row_we) row_vld[row_waddr] <= 1'b1;
      if (row_re) rd_vld <= row_vld[row_raddr];
    end
  end

  always_comb begin
    q_we    = cmd.start | cmd.root | (cmd.scan & cand[VW]);
    q_waddr = cmd.start ? '0 : tail[VW-1:0];
    priority if (cmd.start) q_wdata = va;
    else if (cmd.root)      q_wdata = vtx_t'(unv[VW-1:0]) + 1'b1;
    else                    q_wdata = vtx_t'(cand[VW-1:0]) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_we)    q_mem[q_waddr] <= q_wdata;
    if (cmd.deq) q_rdata <= q_mem[head[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      visited  <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.start) begin
        head     <= '0;
        tail     <= (VW+1)'(1);
        visited  <= onehot(vidx(va));
        emit_cnt <= '0;
      end else begin
        if (cmd.root) begin
          tail    <= tail + 1'b1;
          visited <= visited | onehot(unv[VW-1:0]);
        end else if (cmd.scan && cand[VW]) begin
          tail    <= tail + 1'b1;
          visited <= visited | onehot(cand[VW-1:0]);
        end
        if (cmd.deq)  head     <= head + 1'b1;
        if (cmd.emit) emit_cnt <= emit_cnt + 1'b1;
      end
    end
  end

  // Result register
  logic last_emit;
  assign last_emit = ({1'b0, emit_cnt} + 1'b1) == {1'b0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ack || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ack) begin
      visited_vertex <= '0;
      last           <= 1'b1;
      invalid        <= sts.item_bad;
    end else if (cmd.emit) begin
      visited_vertex <= q_rdata;
      last           <= last_emit;
      invalid        <= 1'b0;
    end
  end

  always_comb begin
    sts.is_trav     = (act == bfsvo_pkg::ACT_TRAVERSE);
    sts.item_bad    = sts.is_trav ? !a_ok : !(a_ok && b_ok);
    sts.out_free    = !out_valid || out_ready;
    sts.cand_found  = cand[VW];
    sts.last_emit   = last_emit;
    sts.queue_empty = (head == tail);
  end

endmodule

// ===== hdl/bfsvo_ctrl.sv =====
// Controller: sequences edge updates and the breadth-first traversal.
module bfsvo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bfsvo_pkg::sts_t sts,
  output bfsvo_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_ADD_RD_A = 9'b000000100,
    S_ADD_WR_A = 9'b000001000,
    S_ADD_WR_B = 9'b000010000,
    S_ACK      = 9'b000100000,
    S_DEQ      = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_SCAN     = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   root_pending, root_pending_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    root_pending_next = root_pending;
    cmd               = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.item_bad) begin
          state_next = S_ACK;
        end else if (sts.is_trav) begin
          cmd.start  = 1'b1;
          state_next = S_DEQ;
        end else begin
          state_next = S_ADD_RD_A;
        end
      end
      S_ADD_RD_A: begin
        cmd.add_rd_a = 1'b1;
        state_next   = S_ADD_WR_A;
      end
      S_ADD_WR_A: begin
        cmd.add_wr_a = 1'b1;
        state_next   = S_ADD_WR_B;
      end
      S_ADD_WR_B: begin
        cmd.add_wr_b = 1'b1;
        state_next   = S_ACK;
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.ack    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEQ: begin
        // A pending root is queued here, in the cycle before its dequeue.
        if (root_pending) begin
          cmd.root          = 1'b1;
          root_pending_next = 1'b0;
        end else begin
          cmd.deq    = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.last_emit ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.cand_found) begin
          cmd.scan = 1'b1;
        end else begin
          // No neighbour left; restart from lowest unvisited if drained.
          root_pending_next = sts.queue_empty;
          state_next        = S_DEQ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_pending <= 1'b0;
    end else begin
      state        <= state_next;
      root_pending <= root_pending_next;
    end
  end

endmodule

// ===== hdl/bfs_visit_order_adjacency_matrix.sv =====
// Top level of the breadth-first visit order block over an adjacency bit matrix.
// Add items set both symmetric bits of an undirected edge among vertices 1..n,
// n = min(vertex_count, VERTICES), and return one acknowledgement (invalid=1 if
// an endpoint is zero or above n). An add does a read-modify-write of both rows in
// the adjacency row store: it passes the check, row-read and first and second
// row-write states in turn, its result is loaded in the acknowledge state and then
// the idle state takes the next item; a rejected item goes from the check state
// straight to the acknowledge state. A traverse item returns every vertex 1..n
// once in breadth-first order, restarting from the lowest unvisited vertex, with
// last on the final one. Its steps are a check, a queue read and an emit with its
// row read for each vertex, a scan step for each vertex but the last, one step per
// queued neighbour (n - R, for R searches including the first), one per restart
// (R - 1) and the idle step taking the next item. A result held by out_ready
// stalls the next emit or ack. Items are taken one at a time; a finished result
// waits in the output register while the next item is taken. The row store is
// cleared at reset through per-row valid bits, so no clearing pass is needed.
// vertex_count resets to 32 and may be written only when idle.
module bfs_visit_order_adjacency_matrix #(
  parameter int VERTICES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [bfsvo_pkg::VTX_W-1:0] first_vertex,
  input  logic [bfsvo_pkg::VTX_W-1:0] second_vertex,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfsvo_pkg::VTX_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfsvo_pkg::VTX_W-1:0] visited_vertex,
  output logic                        last,
  output logic                        invalid
);

  bfsvo_pkg::cmd_t cmd;
  bfsvo_pkg::sts_t sts;

  bfsvo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfsvo_dp #(
    .VERTICES (VERTICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .first_vertex   (first_vertex),
    .second_vertex  (second_vertex),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .visited_vertex (visited_vertex),
    .last           (last),
    .invalid        (invalid)
  );

endmodule
